>>> rtl/dq_pkg.sv
package dq_pkg;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_POP_FRONT  = 2'd1,
        FUNC_PUSH_BACK  = 2'd2,
        FUNC_POP_BACK   = 2'd3
    } func_t;

    // result status codes carried on the output tuser
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    localparam int FUNC_BITS   = 2;
    localparam int STATUS_BITS = 2;

    // store access request from pointer logic to the word store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

>>> rtl/dq_store.sv
module dq_store #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int IDX_W     = 4
) (
    input  logic                  clk,
    input  dq_pkg::mem_ctl_t      ctl,
    input  logic [IDX_W-1:0]      addr,
    input  logic [WORD_BITS-1:0]  wr_data,
    output logic [WORD_BITS-1:0]  rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dq_ptr.sv
module dq_ptr #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  dq_pkg::func_t        func,
    output dq_pkg::mem_ctl_t     ctl,
    output logic [IDX_W-1:0]     addr,
    output dq_pkg::status_t      status,
    output logic [CNT_W-1:0]     count_after
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg,  back_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full, empty;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        wrap_inc = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        wrap_dec = (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        ctl        = '0;
        addr       = front_reg;
        status     = dq_pkg::STATUS_DONE;
        case (func)
            dq_pkg::FUNC_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = dq_pkg::STATUS_FULL;
                end
                else
                begin
                    front_next = wrap_dec(front_reg);
                    addr       = front_next;
                    ctl.wr_en  = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::FUNC_POP_FRONT:
            begin
                if (empty)
                begin
                    status = dq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    addr       = front_reg;
                    ctl.rd_en  = accept;
                    front_next = wrap_inc(front_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            dq_pkg::FUNC_PUSH_BACK:
            begin
                if (full)
                begin
                    status = dq_pkg::STATUS_FULL;
                end
                else
                begin
                    back_next  = wrap_inc(back_reg);
                    addr       = back_next;
                    ctl.wr_en  = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                if (empty)
                begin
                    status = dq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    addr       = back_reg;
                    ctl.rd_en  = accept;
                    back_next  = wrap_dec(back_reg);
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
    end

    assign count_after = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= LAST_IDX;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // occupancy never goes past the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("held count beyond depth");

    // a refused push only happens on a full queue and leaves pointers alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status == dq_pkg::STATUS_FULL) |=>
        (count_reg == FULL_CNT) && $stable(front_reg) && $stable(back_reg))
        else $error("refused push changed state");

    // an empty queue has the back pointer one slot before the front
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (back_reg == wrap_dec(front_reg)))
        else $error("pointers inconsistent while empty");

    // a store write and a store read never share one cycle
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr_en && ctl.rd_en))
        else $error("store read and write together");

endmodule

>>> rtl/double_ended_queue_top.sv
// double-ended queue of signed words held in a circular store
//
// input channel s_*: one item per operation; s_tuser carries the operation
// (push front, pop front, push back, pop back), s_tdata the word to push
// (ignored by pops). output channel m_*: exactly one result item per input
// item, in order; m_tuser carries the status (done, empty on pop, full on
// push), m_tdata the popped word (zero unless a pop succeeded) and the
// occupancy after the operation.
//
// timing: the result is valid in the cycle after its item is accepted; a pop
// reads the word store at the accept edge and the registered read data is
// presented with the result. throughput: one item per cycle while m_tready
// stays high, set by the single store port that each item uses at most once.
//
// stall: while a result is held and m_tready is low, s_tready is low; the
// held result and its store read data stay stable until taken.
// reset: queue empty, front slot zero, back slot one before front, no
// result pending; store contents are not cleared, no clearing pass.
module double_ended_queue_top #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int IN_W     = ((WORD_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((WORD_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,   // value
    input  logic [1:0]             s_tuser,   // func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // popped_word, occupancy
    output logic [1:0]             m_tuser    // status
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                    accept;
    dq_pkg::func_t           func;
    dq_pkg::mem_ctl_t        ctl;
    logic [IDX_W-1:0]        addr;
    dq_pkg::status_t         status;
    logic [CNT_W-1:0]        count_after;
    logic [WORD_BITS-1:0]    rd_data;
    logic [WORD_BITS-1:0]    popped_word;

    // output register
    logic                    out_valid_reg;
    dq_pkg::status_t         status_reg;
    logic [CNT_W-1:0]        occ_reg;
    logic                    from_mem_reg;

    // accept whenever the output slot is free or drains this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign func     = dq_pkg::func_t'(s_tuser);

    dq_ptr #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ptr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .ctl         (ctl),
        .addr        (addr),
        .status      (status),
        .count_after (count_after)
    );

    dq_store #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .addr    (addr),
        .wr_data (s_tdata[WORD_BITS-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status;
            occ_reg      <= count_after;
            from_mem_reg <= ctl.rd_en;
        end
    end

    // store read data is held until the next accepted pop
    assign popped_word = from_mem_reg ? rd_data : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_W'({occ_reg, popped_word});

    // no new item while a result is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !accept)
        else $error("item accepted over a stalled result");

    // every accepted item is followed by a pending result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    // a successful pop leaves room for at least one word
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && from_mem_reg) |->
        (status_reg == dq_pkg::STATUS_DONE && occ_reg < CNT_W'(DEPTH)))
        else $error("pop result inconsistent");

endmodule
